// ===== rtl/fqp_pkg.sv =====
package fqp_pkg;

    localparam int SPACE_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QP_W            = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_SP   = 8'h20;

    typedef enum logic [1:0] {
        K_HEAD   = 2'd0,
        K_SEQ    = 2'd1,
        K_QUAL   = 2'd2,
        K_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        R_OK           = 3'd0,
        R_EMPTY_SEQ    = 3'd1,
        R_NO_PLUS      = 3'd2,
        R_EMPTY_QUAL   = 3'd3,
        R_LEN_MISMATCH = 3'd4,
        R_EARLY_END    = 3'd5,
        R_WS_OVERFLOW  = 3'd6
    } reason_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        reason_t     reason;
        logic [15:0] seq_len;
        logic [15:0] qual_len;
        logic        last;
    } cmd_t;

    function automatic reason_t keep_first(reason_t cur, reason_t code);
        return (cur == R_OK) ? code : cur;
    endfunction

endpackage

// ===== rtl/fqp_ifs.sv =====
interface fqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, data_byte, stream_end, input ready);
    modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface fqp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        record_bad;
    logic [2:0]  reason;
    logic [15:0] seq_length;
    logic [15:0] qual_length;
    logic        last;

    modport source (output valid, kind, out_byte, record_bad, reason, seq_length,
                    qual_length, last, input ready);
    modport sink   (input valid, kind, out_byte, record_bad, reason, seq_length,
                    qual_length, last, output ready);
endinterface

// ===== rtl/fastq_record_parser_core.sv =====
// path: the first result of a word goes from the front's pending registers through a
// queue entry to the output register; the front sequencer issues one item per cycle
// while the queue is not full (held cr, stored spaces, byte, status)
// a 4-entry queue and an output register let front and back stall on their own
// reset: rst_n is asynchronous and active low; the parser returns to header search,
// queue and output register empty, no clearing pass
module fastq_record_parser_core #(
    parameter int SPACE_DEPTH = fqp_pkg::SPACE_DEPTH_DEF,
    parameter int COUNT_BITS  = fqp_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    fqp_in_if.sink           in_ch,
    fqp_out_if.source        out_ch
);
    import fqp_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_pop;
    logic queue_valid;

    fqp_front #(
        .SPACE_DEPTH (SPACE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .data_byte  (in_ch.data_byte),
        .stream_end (in_ch.stream_end),
        .in_ready   (in_ch.ready),
        .cmd_valid  (front_push),
        .cmd        (front_cmd),
        .cmd_full   (queue_full)
    );

    fqp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_cmd),
        .not_empty (queue_valid)
    );

    fqp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (queue_valid),
        .q_data      (queue_cmd),
        .q_pop       (queue_pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .kind        (out_ch.kind),
        .out_byte    (out_ch.out_byte),
        .record_bad  (out_ch.record_bad),
        .reason      (out_ch.reason),
        .seq_length  (out_ch.seq_length),
        .qual_length (out_ch.qual_length),
        .last        (out_ch.last)
    );

    // a status always closes the results of its word
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == K_STATUS) |-> out_ch.last)
        else $error("status item without last");

    a_bad_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == K_STATUS) |->
            (out_ch.record_bad == (out_ch.reason != R_OK)))
        else $error("record_bad disagrees with reason");

    a_content_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind != K_STATUS) |->
            (out_ch.reason == R_OK && !out_ch.record_bad && out_ch.seq_length == 16'h0000))
        else $error("content item carries status fields");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !front_push)
        else $error("queue written while full");

endmodule

// ===== rtl/fqp_front.sv =====
module fqp_front #(
    parameter int SPACE_DEPTH = fqp_pkg::SPACE_DEPTH_DEF,
    parameter int COUNT_BITS  = fqp_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    data_byte,
    input  logic          stream_end,
    output logic          in_ready,
    output logic          cmd_valid,
    output fqp_pkg::cmd_t cmd,
    input  logic          cmd_full
);
    import fqp_pkg::*;

    localparam int CNT_W = $clog2(SPACE_DEPTH + 1);
    localparam int IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int ADD_W = $clog2(SPACE_DEPTH + 2);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_HEAD,
        PH_SEQ,
        PH_PLUS,
        PH_QUAL
    } phase_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] c,
                                                       logic [ADD_W-1:0] a);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS + 1)'(a);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [15:0] sat16(logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    // parse state
    phase_t                phase_reg, phase_next;
    logic                  line_start_reg, line_start_next;
    logic                  in_at_reg, in_at_next;
    logic                  held_cr_reg, held_cr_next;
    logic                  seen_reg, seen_next;
    logic [CNT_W-1:0]      space_count_reg, space_count_next;
    logic [COUNT_BITS-1:0] seq_count_reg, seq_count_next;
    logic [COUNT_BITS-1:0] qual_count_reg, qual_count_next;
    reason_t               fault_reg, fault_next;

    logic [7:0]            space_store [SPACE_DEPTH];

    // pending items of the current word
    logic                  cr_pend_reg;
    logic [CNT_W-1:0]      drain_reg;
    logic                  byte_pend_reg;
    logic [7:0]            byte_val_reg;
    kind_t                 byte_kind_reg;
    logic                  stat_pend_reg;
    reason_t               stat_reason_reg;
    logic [15:0]           stat_seq_reg;
    logic [15:0]           stat_qual_reg;

    // decode of the incoming word
    logic                  d_cr;
    logic [CNT_W-1:0]      d_drain;
    logic                  d_byte;
    kind_t                 d_kind;
    logic [ADD_W-1:0]      d_add;
    logic                  d_fin;
    logic                  d_early;
    logic                  st_we;
    logic                  is_ws;

    logic                  busy;
    logic                  accept;
    logic                  pop_cr, pop_drain, pop_byte, pop_stat;

    assign is_ws = (data_byte == CHAR_SP) || (data_byte inside {[8'h09:8'h0D]});

    always_comb
    begin
        phase_next       = phase_reg;
        line_start_next  = line_start_reg;
        in_at_next       = in_at_reg;
        held_cr_next     = held_cr_reg;
        seen_next        = seen_reg;
        space_count_next = space_count_reg;
        seq_count_next   = seq_count_reg;
        qual_count_next  = qual_count_reg;
        fault_next       = fault_reg;
        d_cr             = 1'b0;
        d_drain          = '0;
        d_byte           = 1'b0;
        d_kind           = K_HEAD;
        d_add            = '0;
        d_fin            = 1'b0;
        d_early          = 1'b0;
        st_we            = 1'b0;

        case (phase_reg)
            PH_SEEK:
            begin
                if (line_start_reg && data_byte == CHAR_AT)
                begin
                    phase_next      = PH_HEAD;
                    line_start_next = 1'b0;
                    in_at_next      = 1'b1;
                    held_cr_next    = 1'b0;
                    seq_count_next  = '0;
                    qual_count_next = '0;
                    fault_next      = R_OK;
                end
                else
                begin
                    line_start_next = (data_byte == CHAR_LF);
                end
            end
            PH_HEAD:
            begin
                if (data_byte == CHAR_LF)
                begin
                    phase_next       = PH_SEQ;
                    line_start_next  = 1'b1;
                    seen_next        = 1'b0;
                    space_count_next = '0;
                    held_cr_next     = 1'b0;
                    in_at_next       = 1'b0;
                end
                else if (data_byte == CHAR_CR)
                begin
                    d_cr         = held_cr_reg;
                    held_cr_next = 1'b1;
                    in_at_next   = 1'b0;
                end
                else if (!(data_byte == CHAR_AT && in_at_reg))
                begin
                    d_cr         = held_cr_reg;
                    held_cr_next = 1'b0;
                    in_at_next   = 1'b0;
                    d_byte       = 1'b1;
                end
            end
            PH_SEQ, PH_QUAL:
            begin
                d_kind = (phase_reg == PH_SEQ) ? K_SEQ : K_QUAL;
                if (data_byte == CHAR_LF)
                begin
                    if (phase_reg == PH_SEQ)
                    begin
                        if (seq_count_reg == '0)
                            fault_next = keep_first(fault_next, R_EMPTY_SEQ);
                        phase_next       = PH_PLUS;
                        line_start_next  = 1'b1;
                        seen_next        = 1'b0;
                        space_count_next = '0;
                        held_cr_next     = 1'b0;
                    end
                    else
                    begin
                        d_fin = 1'b1;
                    end
                end
                else
                begin
                    line_start_next = 1'b0;
                    if (is_ws)
                    begin
                        if (seen_reg)
                        begin
                            if (space_count_reg < CNT_W'(SPACE_DEPTH))
                            begin
                                st_we            = 1'b1;
                                space_count_next = space_count_reg + 1'b1;
                            end
                            else
                            begin
                                fault_next = keep_first(fault_next, R_WS_OVERFLOW);
                            end
                        end
                    end
                    else
                    begin
                        d_drain          = space_count_reg;
                        space_count_next = '0;
                        seen_next        = 1'b1;
                        d_byte           = 1'b1;
                        d_add            = ADD_W'(space_count_reg) + 1'b1;
                    end
                end
            end
            PH_PLUS:
            begin
                if (line_start_reg && data_byte != CHAR_PLUS)
                    fault_next = keep_first(fault_next, R_NO_PLUS);
                if (data_byte == CHAR_LF)
                begin
                    phase_next       = PH_QUAL;
                    line_start_next  = 1'b1;
                    seen_next        = 1'b0;
                    space_count_next = '0;
                    held_cr_next     = 1'b0;
                end
                else
                begin
                    line_start_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_SEEK;
            end
        endcase

        if (d_kind == K_SEQ)
            seq_count_next = sat_add(seq_count_reg, d_add);
        if (d_kind == K_QUAL)
            qual_count_next = sat_add(qual_count_reg, d_add);

        if (stream_end && !d_fin)
        begin
            if (phase_next == PH_QUAL && !line_start_next)
                d_fin = 1'b1;
            else if (phase_next != PH_SEEK)
                d_early = 1'b1;
        end

        if (d_fin)
        begin
            if (qual_count_next == '0)
                fault_next = keep_first(fault_next, R_EMPTY_QUAL);
            else if (seq_count_next != qual_count_next)
                fault_next = keep_first(fault_next, R_LEN_MISMATCH);
        end
        if (d_early)
            fault_next = keep_first(fault_next, R_EARLY_END);

        if (d_fin || d_early || stream_end)
        begin
            phase_next       = PH_SEEK;
            line_start_next  = 1'b1;
            seen_next        = 1'b0;
            space_count_next = '0;
            held_cr_next     = 1'b0;
            in_at_next       = 1'b0;
        end
    end

    // item sequencing: held cr, drained spaces, the byte, then the status
    assign busy = cr_pend_reg || (drain_reg != '0) || byte_pend_reg || stat_pend_reg;

    always_comb
    begin
        pop_cr       = 1'b0;
        pop_drain    = 1'b0;
        pop_byte     = 1'b0;
        pop_stat     = 1'b0;
        cmd.kind     = byte_kind_reg;
        cmd.data     = byte_val_reg;
        cmd.reason   = R_OK;
        cmd.seq_len  = '0;
        cmd.qual_len = '0;
        cmd.last     = 1'b0;
        if (cr_pend_reg)
        begin
            pop_cr   = 1'b1;
            cmd.kind = K_HEAD;
            cmd.data = CHAR_CR;
            cmd.last = (drain_reg == '0) && !byte_pend_reg && !stat_pend_reg;
        end
        else if (drain_reg != '0)
        begin
            pop_drain = 1'b1;
            cmd.data  = space_store[0];
            cmd.last  = (drain_reg == CNT_W'(1)) && !byte_pend_reg && !stat_pend_reg;
        end
        else if (byte_pend_reg)
        begin
            pop_byte = 1'b1;
            cmd.last = !stat_pend_reg;
        end
        else
        begin
            pop_stat     = stat_pend_reg;
            cmd.kind     = K_STATUS;
            cmd.data     = '0;
            cmd.reason   = stat_reason_reg;
            cmd.seq_len  = stat_seq_reg;
            cmd.qual_len = stat_qual_reg;
            cmd.last     = 1'b1;
        end
    end

    assign cmd_valid = busy && !cmd_full;
    assign in_ready  = !busy || (cmd_valid && cmd.last);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEEK;
            line_start_reg  <= 1'b1;
            in_at_reg       <= 1'b0;
            held_cr_reg     <= 1'b0;
            seen_reg        <= 1'b0;
            space_count_reg <= '0;
            seq_count_reg   <= '0;
            qual_count_reg  <= '0;
            fault_reg       <= R_OK;
            cr_pend_reg     <= 1'b0;
            drain_reg       <= '0;
            byte_pend_reg   <= 1'b0;
            byte_val_reg    <= '0;
            byte_kind_reg   <= K_HEAD;
            stat_pend_reg   <= 1'b0;
            stat_reason_reg <= R_OK;
            stat_seq_reg    <= '0;
            stat_qual_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            line_start_reg  <= line_start_next;
            in_at_reg       <= in_at_next;
            held_cr_reg     <= held_cr_next;
            seen_reg        <= seen_next;
            space_count_reg <= space_count_next;
            seq_count_reg   <= seq_count_next;
            qual_count_reg  <= qual_count_next;
            fault_reg       <= fault_next;
            cr_pend_reg     <= d_cr;
            drain_reg       <= d_drain;
            byte_pend_reg   <= d_byte;
            byte_val_reg    <= data_byte;
            byte_kind_reg   <= d_kind;
            stat_pend_reg   <= d_fin || d_early;
            stat_reason_reg <= fault_next;
            stat_seq_reg    <= sat16(seq_count_next);
            stat_qual_reg   <= sat16(qual_count_next);
        end
        else if (cmd_valid)
        begin
            if (pop_cr)
                cr_pend_reg <= 1'b0;
            if (pop_drain)
                drain_reg <= drain_reg - 1'b1;
            if (pop_byte)
                byte_pend_reg <= 1'b0;
            if (pop_stat)
                stat_pend_reg <= 1'b0;
        end
    end

    // whitespace store, drained from the head
    always_ff @(posedge clk)
    begin
        if (cmd_valid && pop_drain)
        begin
            for (int i = 0; i < SPACE_DEPTH - 1; i++)
                space_store[i] <= space_store[i+1];
        end
        if (accept && st_we)
            space_store[space_count_reg[IDX_W-1:0]] <= data_byte;
    end

endmodule

// ===== rtl/fqp_queue.sv =====
module fqp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fqp_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output fqp_pkg::cmd_t pop_data,
    output logic          not_empty
);
    import fqp_pkg::*;

    cmd_t            entry [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   count_reg;

    assign full      = (count_reg == (QP_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/fqp_back.sv =====
module fqp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  fqp_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    kind,
    output logic [7:0]    out_byte,
    output logic          record_bad,
    output logic [2:0]    reason,
    output logic [15:0]   seq_length,
    output logic [15:0]   qual_length,
    output logic          last
);
    import fqp_pkg::*;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        bad_reg;
    logic [2:0]  reason_reg;
    logic [15:0] seq_reg;
    logic [15:0] qual_reg;
    logic        last_reg;
    logic        is_status;

    assign q_pop     = q_valid && (!valid_reg || out_ready);
    assign is_status = (q_data.kind == K_STATUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg   <= q_data.kind;
            byte_reg   <= is_status ? 8'h00 : q_data.data;
            bad_reg    <= is_status && (q_data.reason != R_OK);
            reason_reg <= is_status ? q_data.reason : R_OK;
            seq_reg    <= is_status ? q_data.seq_len : 16'h0000;
            qual_reg   <= is_status ? q_data.qual_len : 16'h0000;
            last_reg   <= q_data.last;
        end
    end

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign out_byte    = byte_reg;
    assign record_bad  = bad_reg;
    assign reason      = reason_reg;
    assign seq_length  = seq_reg;
    assign qual_length = qual_reg;
    assign last        = last_reg;

endmodule
